// ===== hdl/assert_macros.svh =====
// assertion macros shared by the escape-time unit
// no dependencies; define SYNTH to compile the bodies away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, checked out of reset
`define MET_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked out of reset
`define MET_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MET_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define MET_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== hdl/met_pkg.sv =====
// shared constants, beat types and saturation helper of the escape-time unit
// no dependencies; imported by every module of the block
package met_pkg;

  // image and number format
  localparam int IMAGE_WIDTH   = 1024;
  localparam int IMAGE_HEIGHT  = 768;
  localparam int FRACTION_BITS = 26;

  // fixed field widths
  localparam int PIXEL_W     = 10;
  localparam int STEP_W      = 27;
  localparam int CENTER_W    = 29;
  localparam int CNT_W       = 12;
  localparam int RED_W       = 8;
  localparam int CFG_DATA_W  = 29;
  localparam int CFG_INDEX_W = 3;

  // coordinate word: six integer bits including sign
  localparam int COORD_W   = FRACTION_BITS + 6;
  // multiplier chain: one digit of the second operand per cell
  localparam int DIGIT_W   = 16;
  localparam int NUM_CELLS = (COORD_W + DIGIT_W - 1) / DIGIT_W;
  localparam int OPB_W     = NUM_CELLS * DIGIT_W;
  localparam int PROD_W    = COORD_W + OPB_W;
  localparam int SCALED_W  = PROD_W - FRACTION_BITS;
  // capped square, at most 16.0
  localparam int SQ_W      = FRACTION_BITS + 5;

  // pixel offset: index minus half size, times step (half size at most 2048)
  localparam int IDX_W  = PIXEL_W + 3;
  localparam int OFF_W  = IDX_W + STEP_W + 1;
  localparam int WIDE_A = (OFF_W > COORD_W + 2) ? OFF_W : COORD_W + 2;
  localparam int WIDE_W = WIDE_A + 1;

  // red level division
  localparam int NUM_W      = CNT_W + RED_W;
  localparam int DIV_STEP_W = $clog2(RED_W + 1);

  localparam logic [SQ_W-1:0] SQ_CAP    = SQ_W'(1) << (FRACTION_BITS + 4);
  localparam logic [SQ_W:0]   ESC_LIMIT = (SQ_W + 1)'(1) << (FRACTION_BITS + 2);
  localparam logic [RED_W-1:0] RED_FULL = {RED_W{1'b1}};

  localparam logic signed [WIDE_W-1:0] FMT_MAX_W =
    {{(WIDE_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] FMT_MIN_W = ~FMT_MAX_W;

  // config register reset values
  localparam logic [STEP_W-1:0]   STEP_X_RESET   = STEP_W'(131072);
  localparam logic [STEP_W-1:0]   STEP_Y_RESET   = STEP_W'(174763);
  localparam logic [CENTER_W-1:0] CENTER_RESET   = '0;
  localparam logic [CNT_W-1:0]    MAX_ITER_RESET = CNT_W'(100);

  // config register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_STEP_X   = 3'd0,
    CFG_STEP_Y   = 3'd1,
    CFG_CENTER_X = 3'd2,
    CFG_CENTER_Y = 3'd3,
    CFG_MAX_ITER = 3'd4
  } cfg_index_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [COORD_W-1:0]        mag_t;
  typedef logic [OPB_W-1:0]          opb_t;
  typedef logic [SQ_W-1:0]           sq_t;

  // channel payloads
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_column;
    logic [PIXEL_W-1:0] pixel_row;
  } pixel_in_t;

  typedef struct packed {
    logic [CNT_W-1:0] iteration_count;
    logic             in_set;
    logic [RED_W-1:0] red_level;
  } result_out_t;

  // beat moving from one multiplier cell to the next
  typedef struct packed {
    logic valid;
    mag_t a;
    opb_t b;
    mag_t acc;
    opb_t lo;
  } cell_beat_t;

  typedef struct packed {
    logic valid;
    mag_t a;
    mag_t b;
  } lane_req_t;

  typedef struct packed {
    logic valid;
    sq_t  sq;
  } lane_rsp_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] numer;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [RED_W-1:0] quotient;
  } div_rsp_t;

  // clamp a wide signed value to the coordinate range
  function automatic coord_t sat_coord(input logic signed [WIDE_W-1:0] v);
    coord_t r;
    if (v > FMT_MAX_W) begin
      r = {1'b0, {(COORD_W - 1){1'b1}}};
    end else if (v < FMT_MIN_W) begin
      r = {1'b1, {(COORD_W - 1){1'b0}}};
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/met_cell.sv =====
// one multiplier cell: adds operand a times one digit of b, shifts a digit out
// depends on met_pkg
module met_cell
  import met_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_beat_t beat_in,
  output cell_beat_t beat_out
);

  localparam int SUM_W = COORD_W + DIGIT_W;

  logic [SUM_W-1:0] sum;
  cell_beat_t       beat_r;

  // partial product plus running upper part
  assign sum = SUM_W'(beat_in.acc)
             + SUM_W'(beat_in.a) * SUM_W'(beat_in.b[DIGIT_W-1:0]);

  // payload hand-over to the next cell, valid bit cleared by reset
  always_ff @(posedge clk) begin
    beat_r.a   <= beat_in.a;
    beat_r.b   <= beat_in.b >> DIGIT_W;
    beat_r.acc <= sum[SUM_W-1:DIGIT_W];
    beat_r.lo  <= {sum[DIGIT_W-1:0], beat_in.lo[OPB_W-1:DIGIT_W]};
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else begin
      beat_r.valid <= beat_in.valid;
    end
  end

  assign beat_out = beat_r;

endmodule

// ===== hdl/met_lane.sv =====
// multiplier lane: chain of cells, then fraction scaling and cap at 16.0
// depends on met_pkg and met_cell
module met_lane
  import met_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  lane_req_t req,
  output lane_rsp_t rsp
);

  cell_beat_t          chain [NUM_CELLS+1];
  logic [PROD_W-1:0]   product;
  logic [SCALED_W-1:0] scaled;
  lane_rsp_t           rsp_r;

  // chain entry: operands in, empty accumulator
  assign chain[0] = '{valid: req.valid, a: req.a, b: OPB_W'(req.b), acc: '0, lo: '0};

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    met_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .beat_in  (chain[k]),
      .beat_out (chain[k+1])
    );
  end

  // full product, drop the fraction bits
  assign product = {chain[NUM_CELLS].acc, chain[NUM_CELLS].lo};
  assign scaled  = product[PROD_W-1:FRACTION_BITS];

  // capped square and its valid bit
  always_ff @(posedge clk) begin
    if (scaled > SCALED_W'(SQ_CAP)) begin
      rsp_r.sq <= SQ_CAP;
    end else begin
      rsp_r.sq <= scaled[SQ_W-1:0];
    end
    if (!rst_n) begin
      rsp_r.valid <= 1'b0;
    end else begin
      rsp_r.valid <= chain[NUM_CELLS].valid;
    end
  end

  assign rsp = rsp_r;

endmodule

// ===== hdl/met_divider.sv =====
// restoring divider for the red level: one quotient bit per cycle
// depends on met_pkg
module met_divider
  import met_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [CNT_W-1:0]      rem_r;
  logic [RED_W-1:0]      low_r;
  logic [CNT_W-1:0]      den_r;
  logic [DIV_STEP_W-1:0] steps_r;
  logic                  done_r;
  logic [CNT_W:0]        cand;
  logic [CNT_W:0]        diff;
  logic                  ge;

  // trial subtract of the divisor
  assign cand = {rem_r, low_r[RED_W-1]};
  assign diff = cand - {1'b0, den_r};
  assign ge   = (cand >= {1'b0, den_r});

  // step counter and done strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        steps_r <= DIV_STEP_W'(RED_W);
      end else if (steps_r != '0) begin
        steps_r <= steps_r - 1'b1;
        done_r  <= (steps_r == DIV_STEP_W'(1));
      end
    end
  end

  // remainder and quotient shift register; quotient < 2^RED_W so the
  // upper numerator bits start below the divisor
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.numer[NUM_W-1:RED_W];
      low_r <= req.numer[RED_W-1:0];
      den_r <= req.divisor;
    end else if (steps_r != '0) begin
      rem_r <= ge ? diff[CNT_W-1:0] : cand[CNT_W-1:0];
      low_r <= {low_r[RED_W-2:0], ge};
    end
  end

  assign rsp = '{done: done_r, quotient: low_r};

endmodule

// ===== hdl/mandelbrot_escape_time_unit.sv =====
// top level of the mandelbrot escape-time unit: config registers, pixel
// mapping, iteration sequencer, three multiplier lanes and the red divider
// depends on met_pkg, met_lane, met_divider and assert_macros.svh
//
// channel   ports                         handshake
// input     start, busy, in_data          beat taken when start && !busy
// result    out_strobe, out_data          one-cycle strobe, cannot be held off
// config    cfg_we, cfg_index, cfg_data   write taken when cfg_we, no wait
//
// a pixel is mapped in the offset multiply and center add states; each iteration
// then launches the lanes and passes through every cell of the multiplier chain
// and then the capping register; an escaping test also starts the red divider,
// while reaching the limit ends the pixel straight from the check state
// reset is synchronous and active low; no clearing pass.
// busy is high from the accepted beat until the result strobe.
`include "assert_macros.svh"

module mandelbrot_escape_time_unit
  import met_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  pixel_in_t              in_data,
  output logic                   out_strobe,
  output result_out_t            out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP_MUL,
    S_MAP_ADD,
    S_CHECK,
    S_WAIT,
    S_DIV
  } state_t;

  state_t state_r;

  // config registers
  logic [STEP_W-1:0]          step_x_r;
  logic [STEP_W-1:0]          step_y_r;
  logic signed [CENTER_W-1:0] center_x_r;
  logic signed [CENTER_W-1:0] center_y_r;
  logic [CNT_W-1:0]           max_iter_r;

  // per-pixel registers
  pixel_in_t               pix_r;
  logic [CNT_W-1:0]        max_lat_r;
  logic signed [OFF_W-1:0] off_x_r;
  logic signed [OFF_W-1:0] off_y_r;
  coord_t                  cx_r;
  coord_t                  cy_r;
  coord_t                  x_r;
  coord_t                  y_r;
  logic [CNT_W-1:0]        count_r;
  logic                    out_strobe_r;
  result_out_t             out_data_r;

  logic signed [IDX_W-1:0] idx_x;
  logic signed [IDX_W-1:0] idx_y;
  mag_t                    ax;
  mag_t                    ay;
  logic                    launch;
  lane_req_t               req_xx;
  lane_req_t               req_yy;
  lane_req_t               req_xy;
  lane_rsp_t               rsp_xx;
  lane_rsp_t               rsp_yy;
  lane_rsp_t               rsp_xy;
  logic [SQ_W:0]           sum_sq;
  logic                    escape;
  logic [SQ_W:0]           xy2;
  logic signed [WIDE_W-1:0] im_term;
  coord_t                  re_nxt;
  coord_t                  im_nxt;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  // config writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_x_r   <= STEP_X_RESET;
      step_y_r   <= STEP_Y_RESET;
      center_x_r <= CENTER_RESET;
      center_y_r <= CENTER_RESET;
      max_iter_r <= MAX_ITER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_X:   step_x_r   <= cfg_data[STEP_W-1:0];
        CFG_STEP_Y:   step_y_r   <= cfg_data[STEP_W-1:0];
        CFG_CENTER_X: center_x_r <= cfg_data[CENTER_W-1:0];
        CFG_CENTER_Y: center_y_r <= cfg_data[CENTER_W-1:0];
        CFG_MAX_ITER: max_iter_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // pixel index relative to the image center
  assign idx_x = $signed(IDX_W'(pix_r.pixel_column)) - $signed(IDX_W'(IMAGE_WIDTH / 2));
  assign idx_y = $signed(IDX_W'(pix_r.pixel_row)) - $signed(IDX_W'(IMAGE_HEIGHT / 2));

  // magnitudes of z for the lanes
  assign ax = x_r[COORD_W-1] ? mag_t'(-x_r) : mag_t'(x_r);
  assign ay = y_r[COORD_W-1] ? mag_t'(-y_r) : mag_t'(y_r);

  // lanes: x^2, y^2 and |x*y| in parallel
  assign launch = (state_r == S_CHECK) && (count_r < max_lat_r);
  assign req_xx = '{valid: launch, a: ax, b: ax};
  assign req_yy = '{valid: launch, a: ay, b: ay};
  assign req_xy = '{valid: launch, a: ax, b: ay};

  met_lane u_lane_xx (.clk(clk), .rst_n(rst_n), .req(req_xx), .rsp(rsp_xx));
  met_lane u_lane_yy (.clk(clk), .rst_n(rst_n), .req(req_yy), .rsp(rsp_yy));
  met_lane u_lane_xy (.clk(clk), .rst_n(rst_n), .req(req_xy), .rsp(rsp_xy));

  // escape test on the sum of squares
  assign sum_sq = {1'b0, rsp_xx.sq} + {1'b0, rsp_yy.sq};
  assign escape = (sum_sq > ESC_LIMIT);

  // z update: re = x^2 - y^2 + cx, im = +-2|xy| (clamped) + cy
  assign re_nxt = sat_coord(WIDE_W'({1'b0, rsp_xx.sq}) - WIDE_W'({1'b0, rsp_yy.sq})
                            + WIDE_W'(cx_r));
  assign xy2     = {rsp_xy.sq, 1'b0};
  assign im_term = (x_r[COORD_W-1] ^ y_r[COORD_W-1]) ?
                   (WIDE_W'(0) - WIDE_W'(xy2)) : WIDE_W'(xy2);
  assign im_nxt  = sat_coord(WIDE_W'(sat_coord(im_term)) + WIDE_W'(cy_r));

  // red level divider: count*255 / limit
  assign div_req = '{
    start:   (state_r == S_WAIT) && rsp_xx.valid && escape,
    numer:   {count_r, {RED_W{1'b0}}} - NUM_W'(count_r),
    divisor: max_lat_r
  };

  met_divider u_divider (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // sequencer, datapath registers and result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            pix_r     <= in_data;
            max_lat_r <= max_iter_r;
            state_r   <= S_MAP_MUL;
          end
        end
        S_MAP_MUL: begin
          off_x_r <= $signed(OFF_W'(idx_x)) * $signed(OFF_W'({1'b0, step_x_r}));
          off_y_r <= $signed(OFF_W'(idx_y)) * $signed(OFF_W'({1'b0, step_y_r}));
          state_r <= S_MAP_ADD;
        end
        S_MAP_ADD: begin
          cx_r    <= sat_coord(WIDE_W'(sat_coord(WIDE_W'(off_x_r)))
                               + WIDE_W'(sat_coord(WIDE_W'(center_x_r))));
          cy_r    <= sat_coord(WIDE_W'(sat_coord(WIDE_W'(off_y_r)))
                               + WIDE_W'(sat_coord(WIDE_W'(center_y_r))));
          x_r     <= '0;
          y_r     <= '0;
          count_r <= '0;
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (count_r >= max_lat_r) begin
            out_strobe_r <= 1'b1;
            out_data_r   <= '{iteration_count: count_r, in_set: 1'b1, red_level: RED_FULL};
            state_r      <= S_IDLE;
          end else begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (rsp_xx.valid) begin
            if (escape) begin
              state_r <= S_DIV;
            end else begin
              x_r     <= re_nxt;
              y_r     <= im_nxt;
              count_r <= count_r + 1'b1;
              state_r <= S_CHECK;
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            out_strobe_r <= 1'b1;
            out_data_r   <= '{iteration_count: count_r, in_set: 1'b0,
                              red_level: div_rsp.quotient};
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // checks on the sequencer
  `MET_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted beat left busy low")
  `MET_ASSERT_IMPL(a_result_idle, clk, rst_n, out_strobe, !busy, "result while still busy")
  `MET_ASSERT_NEXT(a_single_beat, clk, rst_n, out_strobe, !out_strobe, "result strobe repeated")
  `MET_ASSERT_IMPL(a_count_limit, clk, rst_n, out_strobe,
                   out_data.iteration_count <= max_lat_r, "count beyond limit")
  `MET_ASSERT_IMPL(a_in_set_red, clk, rst_n, out_strobe && out_data.in_set,
                   out_data.red_level == RED_FULL, "in-set pixel not at full red")

endmodule
